// ----- rtl/core/ocr_clg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocr_clg_pkg
// Shared constants for the character line grouper: register map, reset
// values, parameter defaults and the fixed-point formats of the overlap ratio.
// ----------------------------------------------------------------------------
package ocr_clg_pkg;

   // Parameter defaults.
   localparam int DEF_MAX_BOXES    = 64;
   localparam int DEF_MAX_LOOKBACK = 8;
   localparam int DEF_COORD_BITS   = 16;

   // Register map.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 17;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOOKBACK  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD = 1'b1;

   localparam int LOOKBACK_BITS  = 4;
   localparam int THRESHOLD_BITS = 17;
   localparam logic [LOOKBACK_BITS-1:0]  LOOKBACK_RESET  = 4'd3;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 17'd32768;

   // Overlap ratio: unsigned, 16 fraction bits, at most 1.0.
   localparam int FRAC_BITS  = 16;
   localparam int RATIO_BITS = FRAC_BITS + 1;

   // Distance weighting 13/100, compared exactly in integers.
   localparam int DIST_SCALE  = 100;
   localparam int DIST_WEIGHT = 13;

endpackage

// ----- rtl/core/ocr_clg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocr_clg_div
// Iterative restoring divider for the overlap ratio: (num << 16) / den with
// num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ocr_clg_div #(
   parameter int COORD_BITS = ocr_clg_pkg::DEF_COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [COORD_BITS-1:0]               num,
   input  logic [COORD_BITS-1:0]               den,
   output logic                                done,
   output logic [ocr_clg_pkg::RATIO_BITS-1:0]  quo
);

   localparam int FB    = ocr_clg_pkg::FRAC_BITS;
   localparam int CNT_W = $clog2(FB + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] den_ff, den_in;
   logic                  int_ff, int_in;
   logic [FB-1:0]         frac_ff, frac_in;
   logic [COORD_BITS:0]   rem_sh;

   // One shift-and-subtract step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      int_in  = int_ff;
      frac_in = frac_ff;
      rem_sh  = {rem_ff[COORD_BITS-1:0], 1'b0};
      if (start) begin
         // A full overlap gives exactly 1.0 and leaves no remainder.
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FB);
         den_in  = den;
         int_in  = (num == den);
         rem_in  = (num == den) ? '0 : {1'b0, num};
         frac_in = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in  = rem_sh - {1'b0, den_ff};
            frac_in = {frac_ff[FB-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            frac_in = {frac_ff[FB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      int_ff  <= int_in;
      frac_ff <= frac_in;
   end

   assign done = done_ff;
   assign quo  = {int_ff, frac_ff};

endmodule

// ----- rtl/core/ocr_char_line_grouper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocr_char_line_grouper
// Groups character boxes into text lines and emits every box with its line.
// ----------------------------------------------------------------------------
// Boxes are taken one per cycle until an item with last_box set. The set is
// then sorted by x and y (counting sort over the box memory), grouped into
// lines (each box is compared with the recent boxes of every existing line,
// using the 16-step overlap-ratio divider where the boxes overlap), ranked by
// the top of each line's first box and emitted one box per result, each line
// visiting the boxes in the sorted order, with any receiver stall holding the
// emission. All state sits in synchronous memories with one registered read
// port and one write port each. No item is taken between the last box and the
// moment the last result is placed in the output register. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module ocr_char_line_grouper #(
   parameter int MAX_BOXES    = ocr_clg_pkg::DEF_MAX_BOXES,
   parameter int MAX_LOOKBACK = ocr_clg_pkg::DEF_MAX_LOOKBACK,
   parameter int COORD_BITS   = ocr_clg_pkg::DEF_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Configuration writes.
   input  logic                                    csr_wr_en,
   input  logic [ocr_clg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ocr_clg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // Box items.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [COORD_BITS-1:0]                   req_x_pos,
   input  logic [COORD_BITS-1:0]                   req_y_pos,
   input  logic [COORD_BITS-1:0]                   req_width,
   input  logic [COORD_BITS-1:0]                   req_height,
   input  logic                                    req_last_box,
   // Result items.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [COORD_BITS-1:0]                   rsp_out_x,
   output logic [COORD_BITS-1:0]                   rsp_out_y,
   output logic [COORD_BITS-1:0]                   rsp_out_width,
   output logic [COORD_BITS-1:0]                   rsp_out_height,
   output logic [$clog2(MAX_BOXES)-1:0]            rsp_line_number,
   output logic                                    rsp_line_end,
   output logic                                    rsp_last_result,
   output logic                                    rsp_overflow
);

   localparam int C       = COORD_BITS;
   localparam int ML      = MAX_LOOKBACK;
   localparam int IDX_W   = $clog2(MAX_BOXES);
   localparam int CNT_W   = $clog2(MAX_BOXES + 1);
   localparam int SLOT_W  = (ML > 1) ? $clog2(ML) : 1;
   localparam int RD      = MAX_BOXES * ML;
   localparam int RA_W    = (RD > 1) ? $clog2(RD) : 1;
   localparam int LB_W    = ($clog2(ML + 1) > ocr_clg_pkg::LOOKBACK_BITS) ?
                            $clog2(ML + 1) : ocr_clg_pkg::LOOKBACK_BITS;
   localparam int TW      = (CNT_W > LB_W) ? CNT_W : LB_W;
   localparam int RB      = ocr_clg_pkg::RATIO_BITS;
   localparam int DEN_W   = C + 8;
   localparam int PROD_W  = RB + DEN_W;
   localparam int THR_B   = ocr_clg_pkg::THRESHOLD_BITS;
   localparam int LKB_B   = ocr_clg_pkg::LOOKBACK_BITS;
   // Box word: {line, x, y, w, h}. Line word: {head_y, len, slot, tail}.
   localparam int BOX_W   = 4 * C + IDX_W;
   localparam int LINE_WD = C + CNT_W + SLOT_W + IDX_W;

   // Sequencer codes.
   localparam logic [4:0] S_LOAD = 5'd0;
   localparam logic [4:0] SO_RI  = 5'd1;
   localparam logic [4:0] SO_KI  = 5'd2;
   localparam logic [4:0] SO_RJ  = 5'd3;
   localparam logic [4:0] SO_CJ  = 5'd4;
   localparam logic [4:0] G_RS   = 5'd5;
   localparam logic [4:0] G_RB   = 5'd6;
   localparam logic [4:0] G_CB   = 5'd7;
   localparam logic [4:0] G_RL   = 5'd8;
   localparam logic [4:0] G_LL   = 5'd9;
   localparam logic [4:0] G_RR   = 5'd10;
   localparam logic [4:0] G_RRB  = 5'd11;
   localparam logic [4:0] G_OV   = 5'd12;
   localparam logic [4:0] G_DV   = 5'd13;
   localparam logic [4:0] G_NX   = 5'd14;
   localparam logic [4:0] G_RT   = 5'd15;
   localparam logic [4:0] G_WM   = 5'd16;
   localparam logic [4:0] G_WC   = 5'd17;
   localparam logic [4:0] G_DEC  = 5'd18;
   localparam logic [4:0] R_RL   = 5'd19;
   localparam logic [4:0] R_LL   = 5'd20;
   localparam logic [4:0] R_RM   = 5'd21;
   localparam logic [4:0] R_CM   = 5'd22;
   localparam logic [4:0] E_RR   = 5'd23;
   localparam logic [4:0] E_RL   = 5'd24;
   localparam logic [4:0] E_LN   = 5'd25;
   localparam logic [4:0] E_RS   = 5'd26;
   localparam logic [4:0] E_RB   = 5'd27;
   localparam logic [4:0] E_CK   = 5'd28;

   // Memories.
   logic [BOX_W-1:0]   box_mem   [MAX_BOXES];
   logic [LINE_WD-1:0] line_mem  [MAX_BOXES];
   logic [IDX_W-1:0]   order_mem [MAX_BOXES];
   logic [IDX_W-1:0]   recent_mem[RD];
   logic [IDX_W-1:0]   rank_mem  [MAX_BOXES];

   logic [BOX_W-1:0]   box_q_ff;
   logic [LINE_WD-1:0] line_q_ff;
   logic [IDX_W-1:0]   order_q_ff, recent_q_ff, rank_q_ff;

   logic               box_re, box_we, line_re, line_we, order_re, order_we;
   logic               recent_re, recent_we, rank_re, rank_we;
   logic [IDX_W-1:0]   box_ra, box_wa, line_ra, line_wa, order_ra, order_wa;
   logic [IDX_W-1:0]   rank_ra, rank_wa, order_wd, rank_wd, recent_wd;
   logic [RA_W-1:0]    recent_ra, recent_wa;
   logic [BOX_W-1:0]   box_wd;
   logic [LINE_WD-1:0] line_wd;

   // Fields of the memory read words.
   logic [C-1:0]       bq_x, bq_y, bq_w, bq_h;
   logic [IDX_W-1:0]   bq_line, lq_tail;
   logic [C-1:0]       lq_head;
   logic [CNT_W-1:0]   lq_len;
   logic [SLOT_W-1:0]  lq_slot;

   assign bq_h    = box_q_ff[C-1:0];
   assign bq_w    = box_q_ff[2*C-1:C];
   assign bq_y    = box_q_ff[3*C-1:2*C];
   assign bq_x    = box_q_ff[4*C-1:3*C];
   assign bq_line = box_q_ff[BOX_W-1:4*C];
   assign lq_tail = line_q_ff[IDX_W-1:0];
   assign lq_slot = line_q_ff[IDX_W+SLOT_W-1:IDX_W];
   assign lq_len  = line_q_ff[IDX_W+SLOT_W+CNT_W-1:IDX_W+SLOT_W];
   assign lq_head = line_q_ff[LINE_WD-1:IDX_W+SLOT_W+CNT_W];

   // Registers.
   logic [4:0]         state_ff, state_in;
   logic [CNT_W-1:0]   box_count_ff, box_count_in, line_total_ff, line_total_in;
   logic               dropped_ff, dropped_in;
   logic [LKB_B-1:0]   lookback_ff;
   logic [THR_B-1:0]   thr_ff;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, cnt_ff, cnt_in;
   logic [C-1:0]       key_x_ff, key_x_in, key_y_ff, key_y_in;
   logic [IDX_W-1:0]   k_ff, k_in, cur_b_ff, cur_b_in, l_ff, l_in;
   logic [C-1:0]       cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C-1:0]       cur_w_ff, cur_w_in, cur_h_ff, cur_h_in;
   logic               have_ff;
   logic [RB-1:0]      best_ff, cand_ff, cand_in;
   logic [IDX_W-1:0]   best_line_ff;
   logic [CNT_W-1:0]   best_len_ff, len_ff, len_in;
   logic [SLOT_W-1:0]  best_slot_ff, slot_ff, slot_in;
   logic [SLOT_W-1:0]  rslot_ff, rslot_in;
   logic [C-1:0]       best_head_ff, head_ff, head_in;
   logic [C-1:0]       best_x_ff, best_w_ff;
   logic [C-1:0]       q_x_ff, q_x_in, q_w_ff, q_w_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [PROD_W-1:0]  prod_l_ff, prod_r_ff;
   logic               cmp_phase_ff, cmp_phase_in;
   logic [C-1:0]       yl_ff, yl_in;
   logic [IDX_W-1:0]   m_ff, m_in, r_ff, r_in, eline_ff, eline_in;
   logic [CNT_W-1:0]   left_ff, left_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]       o_x_ff, o_x_in, o_y_ff, o_y_in, o_w_ff, o_w_in, o_h_ff, o_h_in;
   logic [IDX_W-1:0]   o_line_ff, o_line_in;
   logic               o_end_ff, o_end_in, o_last_ff, o_last_in, o_ovf_ff, o_ovf_in;

   // Divider interface.
   logic               div_start, div_done;
   logic [C-1:0]       div_num, div_den;
   logic [RB-1:0]      div_quo;

   // Combinational helpers.
   logic               in_accept, box_ok, rsp_free, wins;
   logic [CNT_W-1:0]   count_after;
   logic [IDX_W-1:0]   last_box_idx, last_line_idx;
   logic [LB_W-1:0]    lb;
   logic [TW-1:0]      t_next;
   logic [C:0]         ov_top, ov_bot, ov_ba, ov_bb;
   logic [C-1:0]       ov_hmin, dx, wmin;
   logic [DEN_W-1:0]   den_l, den_r;
   logic [IDX_W-1:0]   cnt_next, r_next;
   logic               sort_less, rank_less;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == SLOT_W'(ML - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
      slot_dec = (s == '0) ? SLOT_W'(ML - 1) : s - 1'b1;
   endfunction

   function automatic logic [RA_W-1:0] recent_addr(input logic [IDX_W-1:0] ln,
                                                   input logic [SLOT_W-1:0] s);
      recent_addr = RA_W'(RA_W'(ln) * RA_W'(ML)) + RA_W'(s);
   endfunction

   assign in_accept     = req_valid && !req_stall;
   assign req_stall     = (state_ff != S_LOAD);
   assign box_ok        = (req_width != '0) && (req_height != '0);
   assign count_after   = (box_ok && box_count_ff < CNT_W'(MAX_BOXES)) ?
                          box_count_ff + 1'b1 : box_count_ff;
   assign last_box_idx  = IDX_W'(box_count_ff - 1'b1);
   assign last_line_idx = IDX_W'(line_total_ff - 1'b1);
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign lb            = (LB_W'(lookback_ff) > LB_W'(ML)) ? LB_W'(ML) : LB_W'(lookback_ff);
   assign t_next        = t_ff + 1'b1;

   // Sort key order: x, then y, then arrival.
   assign sort_less = (bq_x < key_x_ff) || (bq_x == key_x_ff && bq_y < key_y_ff) ||
                      (bq_x == key_x_ff && bq_y == key_y_ff && j_ff < i_ff);
   assign cnt_next  = sort_less ? cnt_ff + 1'b1 : cnt_ff;
   // Line rank order: top of first box, then creation.
   assign rank_less = (lq_head < yl_ff) || (lq_head == yl_ff && m_ff < l_ff);
   assign r_next    = rank_less ? r_ff + 1'b1 : r_ff;

   // Vertical overlap of a recent box against the current box.
   assign ov_ba   = {1'b0, bq_y} + {1'b0, bq_h};
   assign ov_bb   = {1'b0, cur_y_ff} + {1'b0, cur_h_ff};
   assign ov_top  = (bq_y > cur_y_ff) ? {1'b0, bq_y} : {1'b0, cur_y_ff};
   assign ov_bot  = (ov_ba < ov_bb) ? ov_ba : ov_bb;
   assign ov_hmin = (bq_h < cur_h_ff) ? bq_h : cur_h_ff;
   assign div_num = C'(ov_bot - ov_top);
   assign div_den = ov_hmin;

   // Distance weighting between the best line's tail and the candidate's.
   assign dx    = (best_x_ff > q_x_ff) ? best_x_ff - q_x_ff : q_x_ff - best_x_ff;
   assign wmin  = (best_w_ff < q_w_ff) ? best_w_ff : q_w_ff;
   assign den_l = DEN_W'(DEN_W'(ocr_clg_pkg::DIST_SCALE) * DEN_W'(wmin)) +
                  DEN_W'(DEN_W'(ocr_clg_pkg::DIST_WEIGHT) * DEN_W'(dx));
   assign den_r = (best_x_ff < q_x_ff) ?
                  DEN_W'(DEN_W'(ocr_clg_pkg::DIST_SCALE) * DEN_W'(wmin)) :
                  DEN_W'(DEN_W'(ocr_clg_pkg::DIST_SCALE) * DEN_W'(wmin)) +
                  DEN_W'(DEN_W'(2 * ocr_clg_pkg::DIST_WEIGHT) * DEN_W'(dx));
   assign wins  = have_ff ? (prod_l_ff > prod_r_ff) : (cand_ff > best_ff);

   ocr_clg_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer: load, sort, group, rank, emit.
   always_comb begin
      state_in      = state_ff;
      box_count_in  = box_count_ff;
      line_total_in = line_total_ff;
      dropped_in    = dropped_ff;
      i_in = i_ff;  j_in = j_ff;  cnt_in = cnt_ff;
      key_x_in = key_x_ff;  key_y_in = key_y_ff;
      k_in = k_ff;  cur_b_in = cur_b_ff;  l_in = l_ff;
      cur_x_in = cur_x_ff;  cur_y_in = cur_y_ff;
      cur_w_in = cur_w_ff;  cur_h_in = cur_h_ff;
      cand_in = cand_ff;
      len_in = len_ff;  slot_in = slot_ff;  rslot_in = rslot_ff;
      head_in = head_ff;  tail_in = tail_ff;  t_in = t_ff;
      q_x_in = q_x_ff;  q_w_in = q_w_ff;
      cmp_phase_in = 1'b0;
      yl_in = yl_ff;  m_in = m_ff;  r_in = r_ff;
      eline_in = eline_ff;  left_in = left_ff;

      rsp_valid_in = (rsp_valid_ff && rsp_stall);
      o_x_in = o_x_ff;  o_y_in = o_y_ff;  o_w_in = o_w_ff;  o_h_in = o_h_ff;
      o_line_in = o_line_ff;  o_end_in = o_end_ff;
      o_last_in = o_last_ff;  o_ovf_in = o_ovf_ff;

      box_re = 1'b0;  box_ra = '0;  box_we = 1'b0;  box_wa = '0;  box_wd = '0;
      line_re = 1'b0; line_ra = '0; line_we = 1'b0; line_wa = '0; line_wd = '0;
      order_re = 1'b0; order_ra = '0; order_we = 1'b0; order_wa = '0; order_wd = '0;
      recent_re = 1'b0; recent_ra = '0; recent_we = 1'b0; recent_wa = '0; recent_wd = '0;
      rank_re = 1'b0; rank_ra = '0; rank_we = 1'b0; rank_wa = '0; rank_wd = '0;
      div_start = 1'b0;

      case (state_ff)
         // Take boxes until the one marked last.
         S_LOAD: begin
            if (in_accept) begin
               if (box_ok && box_count_ff < CNT_W'(MAX_BOXES)) begin
                  box_we = 1'b1;
                  box_wa = box_count_ff[IDX_W-1:0];
                  box_wd = {{IDX_W{1'b0}}, req_x_pos, req_y_pos, req_width, req_height};
               end else if (box_ok) begin
                  dropped_in = 1'b1;
               end
               box_count_in = count_after;
               if (req_last_box) begin
                  if (count_after == '0) begin
                     dropped_in = 1'b0;
                  end else begin
                     i_in     = '0;
                     state_in = SO_RI;
                  end
               end
            end
         end

         // Counting sort: each box's place is the number of boxes before it.
         SO_RI: begin
            box_re   = 1'b1;
            box_ra   = i_ff;
            state_in = SO_KI;
         end
         SO_KI: begin
            key_x_in = bq_x;
            key_y_in = bq_y;
            j_in     = '0;
            cnt_in   = '0;
            state_in = SO_RJ;
         end
         SO_RJ: begin
            box_re   = 1'b1;
            box_ra   = j_ff;
            state_in = SO_CJ;
         end
         SO_CJ: begin
            cnt_in = cnt_next;
            if (j_ff == last_box_idx) begin
               order_we = 1'b1;
               order_wa = cnt_next;
               order_wd = i_ff;
               if (i_ff == last_box_idx) begin
                  k_in          = '0;
                  line_total_in = '0;
                  state_in      = G_RS;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = SO_RI;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = SO_RJ;
            end
         end

         // Grouping: fetch the next box in sorted order.
         G_RS: begin
            order_re = 1'b1;
            order_ra = k_ff;
            state_in = G_RB;
         end
         G_RB: begin
            box_re   = 1'b1;
            box_ra   = order_q_ff;
            cur_b_in = order_q_ff;
            state_in = G_CB;
         end
         G_CB: begin
            cur_x_in = bq_x;
            cur_y_in = bq_y;
            cur_w_in = bq_w;
            cur_h_in = bq_h;
            l_in     = '0;
            state_in = (line_total_ff == '0) ? G_DEC : G_RL;
         end

         // Visit each existing line.
         G_RL: begin
            line_re  = 1'b1;
            line_ra  = l_ff;
            state_in = G_LL;
         end
         G_LL: begin
            len_in   = lq_len;
            slot_in  = lq_slot;
            head_in  = lq_head;
            tail_in  = lq_tail;
            rslot_in = slot_dec(lq_slot);
            t_in     = '0;
            cand_in  = '0;
            state_in = (lb == '0) ? G_RT : G_RR;
         end
         G_RR: begin
            recent_re = 1'b1;
            recent_ra = recent_addr(l_ff, rslot_ff);
            state_in  = G_RRB;
         end
         G_RRB: begin
            box_re   = 1'b1;
            box_ra   = recent_q_ff;
            state_in = G_OV;
         end
         G_OV: begin
            if (ov_bot > ov_top) begin
               div_start = 1'b1;
               state_in  = G_DV;
            end else begin
               state_in = G_NX;
            end
         end
         G_DV: begin
            if (div_done) begin
               if (div_quo > cand_ff) begin
                  cand_in = div_quo;
               end
               state_in = G_NX;
            end
         end
         G_NX: begin
            if (t_next >= TW'(len_ff) || t_next >= TW'(lb)) begin
               state_in = G_RT;
            end else begin
               t_in     = t_next;
               rslot_in = slot_dec(rslot_ff);
               state_in = G_RR;
            end
         end

         // Weigh the candidate against the best line so far.
         G_RT: begin
            box_re   = 1'b1;
            box_ra   = tail_ff;
            state_in = G_WM;
         end
         G_WM: begin
            q_x_in   = bq_x;
            q_w_in   = bq_w;
            state_in = G_WC;
         end
         G_WC: begin
            if (!cmp_phase_ff) begin
               // The products are registered in the first cycle.
               cmp_phase_in = 1'b1;
            end else begin
               l_in     = l_ff + 1'b1;
               state_in = (l_ff == last_line_idx) ? G_DEC : G_RL;
            end
         end

         // Join the best line or open a new one.
         G_DEC: begin
            if (have_ff && best_ff > thr_ff) begin
               recent_we = 1'b1;
               recent_wa = recent_addr(best_line_ff, best_slot_ff);
               recent_wd = cur_b_ff;
               line_we   = 1'b1;
               line_wa   = best_line_ff;
               line_wd   = {best_head_ff, best_len_ff + 1'b1, slot_inc(best_slot_ff), cur_b_ff};
               box_we    = 1'b1;
               box_wa    = cur_b_ff;
               box_wd    = {best_line_ff, cur_x_ff, cur_y_ff, cur_w_ff, cur_h_ff};
            end else begin
               recent_we     = 1'b1;
               recent_wa     = recent_addr(line_total_ff[IDX_W-1:0], '0);
               recent_wd     = cur_b_ff;
               line_we       = 1'b1;
               line_wa       = line_total_ff[IDX_W-1:0];
               line_wd       = {cur_y_ff, CNT_W'(1), slot_inc('0), cur_b_ff};
               box_we        = 1'b1;
               box_wa        = cur_b_ff;
               box_wd        = {line_total_ff[IDX_W-1:0], cur_x_ff, cur_y_ff,
                                cur_w_ff, cur_h_ff};
               line_total_in = line_total_ff + 1'b1;
            end
            if (k_ff == last_box_idx) begin
               l_in     = '0;
               state_in = R_RL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = G_RS;
            end
         end

         // Ranking: count lines whose first box lies higher, or level and created earlier.
         R_RL: begin
            line_re  = 1'b1;
            line_ra  = l_ff;
            state_in = R_LL;
         end
         R_LL: begin
            yl_in    = lq_head;
            m_in     = '0;
            r_in     = '0;
            state_in = R_RM;
         end
         R_RM: begin
            line_re  = 1'b1;
            line_ra  = m_ff;
            state_in = R_CM;
         end
         R_CM: begin
            r_in = r_next;
            if (m_ff == last_line_idx) begin
               rank_we = 1'b1;
               rank_wa = r_next;
               rank_wd = l_ff;
               if (l_ff == last_line_idx) begin
                  r_in     = '0;
                  state_in = E_RR;
               end else begin
                  l_in     = l_ff + 1'b1;
                  state_in = R_RL;
               end
            end else begin
               m_in     = m_ff + 1'b1;
               state_in = R_RM;
            end
         end

         // Emission: lines in rank order, boxes in sorted order.
         E_RR: begin
            rank_re  = 1'b1;
            rank_ra  = r_ff;
            state_in = E_RL;
         end
         E_RL: begin
            line_re  = 1'b1;
            line_ra  = rank_q_ff;
            eline_in = rank_q_ff;
            state_in = E_LN;
         end
         E_LN: begin
            left_in  = lq_len;
            k_in     = '0;
            state_in = E_RS;
         end
         E_RS: begin
            order_re = 1'b1;
            order_ra = k_ff;
            state_in = E_RB;
         end
         E_RB: begin
            box_re   = 1'b1;
            box_ra   = order_q_ff;
            state_in = E_CK;
         end
         E_CK: begin
            if (bq_line != eline_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = E_RS;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               o_x_in       = bq_x;
               o_y_in       = bq_y;
               o_w_in       = bq_w;
               o_h_in       = bq_h;
               o_line_in    = r_ff;
               o_end_in     = (left_ff == CNT_W'(1));
               o_last_in    = (left_ff == CNT_W'(1)) && (r_ff == last_line_idx);
               o_ovf_in     = dropped_ff;
               left_in      = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  if (r_ff == last_line_idx) begin
                     box_count_in  = '0;
                     line_total_in = '0;
                     dropped_in    = 1'b0;
                     state_in      = S_LOAD;
                  end else begin
                     r_in     = r_ff + 1'b1;
                     state_in = E_RR;
                  end
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = E_RS;
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Memory ports and registered read data.
   always_ff @(posedge clock) begin
      if (box_we)    box_mem[box_wa]       <= box_wd;
      if (line_we)   line_mem[line_wa]     <= line_wd;
      if (order_we)  order_mem[order_wa]   <= order_wd;
      if (recent_we) recent_mem[recent_wa] <= recent_wd;
      if (rank_we)   rank_mem[rank_wa]     <= rank_wd;
      if (box_re)    box_q_ff    <= box_mem[box_ra];
      if (line_re)   line_q_ff   <= line_mem[line_ra];
      if (order_re)  order_q_ff  <= order_mem[order_ra];
      if (recent_re) recent_q_ff <= recent_mem[recent_ra];
      if (rank_re)   rank_q_ff   <= rank_mem[rank_ra];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lookback_ff <= ocr_clg_pkg::LOOKBACK_RESET;
         thr_ff      <= ocr_clg_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ocr_clg_pkg::REG_LOOKBACK:  lookback_ff <= csr_wdata[LKB_B-1:0];
            ocr_clg_pkg::REG_THRESHOLD: thr_ff      <= csr_wdata[THR_B-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         box_count_ff  <= '0;
         line_total_ff <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cmp_phase_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         box_count_ff  <= box_count_in;
         line_total_ff <= line_total_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_phase_ff  <= cmp_phase_in;
      end
      i_ff <= i_in;  j_ff <= j_in;  cnt_ff <= cnt_in;
      key_x_ff <= key_x_in;  key_y_ff <= key_y_in;
      k_ff <= k_in;  cur_b_ff <= cur_b_in;  l_ff <= l_in;
      cur_x_ff <= cur_x_in;  cur_y_ff <= cur_y_in;
      cur_w_ff <= cur_w_in;  cur_h_ff <= cur_h_in;
      cand_ff <= cand_in;
      len_ff <= len_in;  slot_ff <= slot_in;  rslot_ff <= rslot_in;
      head_ff <= head_in;  tail_ff <= tail_in;  t_ff <= t_in;
      q_x_ff <= q_x_in;  q_w_ff <= q_w_in;
      yl_ff <= yl_in;  m_ff <= m_in;  r_ff <= r_in;
      eline_ff <= eline_in;  left_ff <= left_in;
      o_x_ff <= o_x_in;  o_y_ff <= o_y_in;  o_w_ff <= o_w_in;  o_h_ff <= o_h_in;
      o_line_ff <= o_line_in;  o_end_ff <= o_end_in;
      o_last_ff <= o_last_in;  o_ovf_ff <= o_ovf_in;

      // Best line so far and the weighted compare.
      if (state_ff == G_WC && !cmp_phase_ff) begin
         prod_l_ff <= PROD_W'(cand_ff) * PROD_W'(den_l);
         prod_r_ff <= PROD_W'(best_ff) * PROD_W'(den_r);
      end
      if (state_ff == G_CB) begin
         have_ff <= 1'b0;
         best_ff <= '0;
      end else if (state_ff == G_WC && cmp_phase_ff && wins) begin
         have_ff      <= 1'b1;
         best_ff      <= cand_ff;
         best_line_ff <= l_ff;
         best_len_ff  <= len_ff;
         best_slot_ff <= slot_ff;
         best_head_ff <= head_ff;
         best_x_ff    <= q_x_ff;
         best_w_ff    <= q_w_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = o_x_ff;
   assign rsp_out_y       = o_y_ff;
   assign rsp_out_width   = o_w_ff;
   assign rsp_out_height  = o_h_ff;
   assign rsp_line_number = o_line_ff;
   assign rsp_line_end    = o_end_ff;
   assign rsp_last_result = o_last_ff;
   assign rsp_overflow    = o_ovf_ff;

endmodule

// ----- dv/ocr_char_line_grouper_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocr_char_line_grouper_test
// Self-checking bench for the character line grouper. Sets of boxes are sent
// with random gaps and receiver stalls. A behavioral line grouper in the bench
// sorts, groups and ranks each set on its last box and queues the results,
// which are then compared field by field with every result the block emits.
// ----------------------------------------------------------------------------
module ocr_char_line_grouper_test;

   localparam int CAPACITY = ocr_clg_pkg::DEF_MAX_BOXES;
   localparam int RECENT   = ocr_clg_pkg::DEF_MAX_LOOKBACK;

   typedef struct {
      logic [15:0] x, y, w, h;
   } box_type;

   typedef struct {
      logic [15:0] x, y, w, h;
      logic [5:0]  line;
      logic        line_end, last, ovf;
   } placed_box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [ocr_clg_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ocr_clg_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_x_pos = '0, req_y_pos = '0, req_width = '0, req_height = '0;
   logic req_last_box = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_out_x, rsp_out_y, rsp_out_width, rsp_out_height;
   logic [5:0]  rsp_line_number;
   logic rsp_line_end, rsp_last_result, rsp_overflow;

   // Bench state: expected results, error count, idle control.
   placed_box_type expected_boxes[$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          hold_request = 0;
   bit          quiet = 1'b0;

   // Shadow of the block: configuration and the set being loaded.
   int unsigned cfg_lookback  = ocr_clg_pkg::LOOKBACK_RESET;
   int unsigned cfg_threshold = ocr_clg_pkg::THRESHOLD_RESET;
   int unsigned bx[CAPACITY], by[CAPACITY], bw[CAPACITY], bh[CAPACITY];
   int unsigned n_boxes = 0;
   bit          lost_boxes = 1'b0;

   ocr_char_line_grouper u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos),
      .req_width(req_width), .req_height(req_height),
      .req_last_box(req_last_box),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_width(rsp_out_width), .rsp_out_height(rsp_out_height),
      .rsp_line_number(rsp_line_number), .rsp_line_end(rsp_line_end),
      .rsp_last_result(rsp_last_result), .rsp_overflow(rsp_overflow)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, a few long ones, none at all in quiet stretches.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Vertical overlap of two stored boxes as an unsigned Q.16 ratio.
   function automatic longint unsigned overlap_ratio(int unsigned a, int unsigned b);
      longint unsigned top, bot, hmin;
      top  = (by[a] > by[b]) ? by[a] : by[b];
      bot  = ((by[a] + bh[a]) < (by[b] + bh[b])) ? by[a] + bh[a] : by[b] + bh[b];
      hmin = (bh[a] < bh[b]) ? bh[a] : bh[b];
      if (bot <= top) return 0;
      return ((bot - top) << 16) / hmin;
   endfunction

   // Takes one accepted box; on the last one it groups the set into lines
   // and queues one expected result per stored box in line rank order.
   function automatic void group_lines(box_type bx_in, logic last);
      int unsigned order[CAPACITY], recent[CAPACITY][RECENT];
      int unsigned len[CAPACITY], tail[CAPACITY], head[CAPACITY];
      int unsigned owner[CAPACITY], by_rank[CAPACITY];
      int unsigned lb, lines, i, j, k, l, t, key, b, nc, p, q, r, left, best_line;
      longint unsigned best, cand, rr, xp, xq, d, wm, den;
      bit have, wins;
      placed_box_type pb;
      if (bx_in.w != 0 && bx_in.h != 0) begin
         if (n_boxes < CAPACITY) begin
            bx[n_boxes] = 32'(bx_in.x); by[n_boxes] = 32'(bx_in.y);
            bw[n_boxes] = 32'(bx_in.w); bh[n_boxes] = 32'(bx_in.h);
            n_boxes++;
         end else begin
            lost_boxes = 1'b1;
         end
      end
      if (!last) return;
      if (n_boxes == 0) begin
         lost_boxes = 1'b0;
         return;
      end
      lb = (cfg_lookback > RECENT) ? RECENT : cfg_lookback;
      // Stable insertion sort by x, then y.
      for (i = 0; i < n_boxes; i++) begin
         key = i;
         j = i;
         while (j > 0 && (bx[key] < bx[order[j-1]] ||
                (bx[key] == bx[order[j-1]] && by[key] < by[order[j-1]]))) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
      end
      // Each box joins the best line or opens a new one.
      lines = 0;
      for (k = 0; k < n_boxes; k++) begin
         b = order[k];
         best = 0;
         best_line = 0;
         have = 1'b0;
         for (l = 0; l < lines; l++) begin
            nc = (len[l] < lb) ? len[l] : lb;
            cand = 0;
            for (t = 0; t < nc; t++) begin
               rr = overlap_ratio(recent[l][(len[l] - 1 - t) % RECENT], b);
               if (rr > cand) cand = rr;
            end
            if (!have) begin
               wins = cand > best;
            end else begin
               p = tail[best_line];
               q = tail[l];
               xp = bx[p];
               xq = bx[q];
               d = (xp > xq) ? xp - xq : xq - xp;
               wm = (bw[p] < bw[q]) ? bw[p] : bw[q];
               den = 100 * wm + 13 * d;
               if (xp < xq) wins = cand * den > best * (100 * wm);
               else         wins = cand * den > best * (100 * wm + 26 * d);
            end
            if (wins) begin
               best = cand;
               best_line = l;
               have = 1'b1;
            end
         end
         if (!(have && best > cfg_threshold)) begin
            best_line = lines++;
            len[best_line] = 0;
            head[best_line] = b;
         end
         recent[best_line][len[best_line] % RECENT] = b;
         len[best_line]++;
         tail[best_line] = b;
         owner[b] = best_line;
      end
      // Rank lines by the top of their first box, ties in creation order.
      for (l = 0; l < lines; l++) begin
         r = 0;
         for (j = 0; j < lines; j++)
            if (by[head[j]] < by[head[l]] || (by[head[j]] == by[head[l]] && j < l)) r++;
         by_rank[r] = l;
      end
      for (r = 0; r < lines; r++) begin
         l = by_rank[r];
         left = len[l];
         for (k = 0; k < n_boxes; k++) begin
            b = order[k];
            if (owner[b] != l) continue;
            left--;
            pb.x = 16'(bx[b]); pb.y = 16'(by[b]); pb.w = 16'(bw[b]); pb.h = 16'(bh[b]);
            pb.line = 6'(r);
            pb.line_end = (left == 0);
            pb.last = 1'b0;
            pb.ovf = lost_boxes;
            expected_boxes = {expected_boxes, pb};
         end
      end
      expected_boxes[expected_boxes.size()-1].last = 1'b1;
      n_boxes = 0;
      lost_boxes = 1'b0;
   endfunction

   // Receiver: random stalls, plus long holds on request, counted here.
   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 25) begin
         stall_left = gap_len();
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   // Checks every accepted result against the oldest expected one.
   always @(posedge clock) begin
      placed_box_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: x=%0d y=%0d line=%0d",
                        rsp_out_x, rsp_out_y, rsp_line_number);
         end else begin
            e = expected_boxes.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_width !== e.w ||
                rsp_out_height !== e.h || rsp_line_number !== e.line ||
                rsp_line_end !== e.line_end || rsp_last_result !== e.last ||
                rsp_overflow !== e.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected x=%0d y=%0d w=%0d h=%0d line=%0d ",
                            "end=%b last=%b ovf=%b, got x=%0d y=%0d w=%0d h=%0d ",
                            "line=%0d end=%b last=%b ovf=%b"},
                           e.x, e.y, e.w, e.h, e.line, e.line_end, e.last, e.ovf,
                           rsp_out_x, rsp_out_y, rsp_out_width, rsp_out_height,
                           rsp_line_number, rsp_line_end, rsp_last_result,
                           rsp_overflow);
            end
         end
      end
   end

   // Offers one item after a random gap and waits until it is taken.
   task automatic send_box(box_type bv, logic last);
      int gap;
      gap = gap_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_x_pos <= bv.x; req_y_pos <= bv.y;
      req_width <= bv.w; req_height <= bv.h;
      req_last_box <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      group_lines(bv, last);
      items_sent++;
   endtask

   task automatic send_fields(int x, int y, int w, int h, logic last);
      box_type bv;
      bv.x = 16'(x); bv.y = 16'(y); bv.w = 16'(w); bv.h = 16'(h);
      send_box(bv, last);
   endtask

   // Waits until every expected result is out and the block has settled.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [ocr_clg_pkg::CSR_INDEX_BITS-1:0] idx,
                            int unsigned value);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= ocr_clg_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ocr_clg_pkg::REG_LOOKBACK) cfg_lookback = value & 4'hF;
      else cfg_threshold = value & 17'h1FFFF;
   endtask

   // Sends a set of text-like lines in shuffled arrival order.
   task automatic send_text_set(int max_lines, int max_chars);
      box_type set_q[$];
      box_type bv, tmp;
      int nl, nch, base, hgt, xc, i, j, pitch;
      nl = $urandom_range(1, max_lines);
      pitch = $urandom_range(10, 80);
      base = $urandom_range(0, 50000);
      for (i = 0; i < nl; i++) begin
         hgt = $urandom_range(8, 60);
         xc = $urandom_range(0, 2000);
         nch = $urandom_range(1, max_chars);
         for (j = 0; j < nch; j++) begin
            xc += $urandom_range(0, 40);
            bv.x = 16'(xc);
            bv.y = 16'(base + i * pitch + $urandom_range(0, hgt / 4));
            bv.w = 16'($urandom_range(3, 40));
            bv.h = 16'(hgt - $urandom_range(0, hgt / 4));
            if ($urandom_range(0, 29) == 0) begin
               if ($urandom_range(0, 1)) bv.w = 0;
               else bv.h = 0;
            end
            set_q = {set_q, bv};
         end
      end
      for (i = set_q.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = set_q[i];
         set_q[i] = set_q[j];
         set_q[j] = tmp;
      end
      for (i = 0; i < set_q.size(); i++)
         send_box(set_q[i], i == set_q.size() - 1);
   endtask

   // Sends a short set of boxes with fully random fields.
   task automatic send_noise_set();
      int n, i;
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
         send_fields($urandom_range(0, 65535), $urandom_range(0, 65535),
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 65535),
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 65535),
                     i == n - 1);
   endtask

   // Field extremes, ties, zero sizes, empty sets and a simple two-line set.
   task automatic test_directed();
      send_fields(0, 0, 1, 1, 1'b1);
      send_fields(65535, 65535, 65535, 65535, 1'b1);
      send_fields(100, 100, 0, 20, 1'b1);
      send_fields(100, 100, 20, 0, 1'b0);
      send_fields(7, 9, 10, 10, 1'b0);
      send_fields(7, 9, 12, 10, 1'b0);
      send_fields(7, 3, 10, 10, 1'b0);
      send_fields(0, 0, 0, 0, 1'b1);
      send_fields(10, 10, 10, 20, 1'b0);
      send_fields(30, 12, 10, 20, 1'b0);
      send_fields(20, 60, 10, 20, 1'b0);
      send_fields(50, 62, 10, 20, 1'b0);
      send_fields(40, 11, 10, 18, 1'b1);
      send_fields(0, 0, 65535, 1, 1'b0);
      send_fields(65535, 0, 1, 65535, 1'b1);
      send_fields(5, 5, 5, 5, 1'b0);
      send_fields(5, 5, 5, 5, 1'b1);
   endtask

   // Every register through its extremes and a few values between.
   task automatic test_config_sweep();
      int unsigned lbs[7] = '{0, 1, 8, 15, 2, 5, 3};
      int unsigned ths[7] = '{0, 0, 65536, 131071, 65535, 1, 32768};
      int s, n;
      for (s = 0; s < 7; s++) begin
         write_reg(ocr_clg_pkg::REG_LOOKBACK, lbs[s]);
         write_reg(ocr_clg_pkg::REG_THRESHOLD, ths[s]);
         for (n = 0; n < 3; n++) send_text_set(3, 6);
      end
   endtask

   // Full store with dropped boxes, then a long receiver hold.
   task automatic test_capacity_and_hold();
      int i;
      quiet = 1'b1;
      for (i = 0; i < CAPACITY + 6; i++)
         send_fields(i * 40 + $urandom_range(0, 30), 1000 + (i % 4) * 50 +
                     $urandom_range(0, 5), 20, 30, i == CAPACITY + 5);
      send_fields(12, 34, 5, 6, 1'b1);
      drain();
      hold_request = 800;
      for (i = 0; i < 4; i++) send_text_set(2, 8);
      quiet = 1'b0;
      drain();
   endtask

   // Mostly well-formed text sets with random content, some noise.
   task automatic test_random();
      while (items_sent < 330) begin
         if ($urandom_range(0, 9) == 0) quiet = ~quiet;
         if ($urandom_range(0, 4) == 0) send_noise_set();
         else send_text_set(4, 5);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_capacity_and_hold();
      test_config_sweep();
      write_reg(ocr_clg_pkg::REG_LOOKBACK, 4);
      write_reg(ocr_clg_pkg::REG_THRESHOLD, 30000);
      test_random();
      drain();
      if (mismatches == 0 && expected_boxes.size() == 0)
         $display("ocr_char_line_grouper regression: pass");
      else
         $display("ocr_char_line_grouper regression: fail");
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #200_000_000;
      $display("ocr_char_line_grouper regression: fail");
      $finish;
   end

endmodule
